// ----- rtl/swa_pkg.sv -----
// ----------------------------------------------------------------------------
// swa_pkg: shared definitions for the step function window average
// Field widths, register indexes, result status codes and reset values.
// ----------------------------------------------------------------------------
package swa_pkg;

  // Fixed widths of the stream and register fields
  localparam int FIELD_BITS     = 32;
  localparam int STATUS_BITS    = 2;
  localparam int IN_TDATA_BITS  = 64;
  localparam int OUT_TDATA_BITS = 40;

  // Default operand widths
  localparam int KEY_BITS_DEFAULT   = 32;
  localparam int VALUE_BITS_DEFAULT = 32;

  // Moment accumulator and divider step counter
  localparam int ACC_BITS = 64;
  localparam int CNT_BITS = $clog2(ACC_BITS);

  // Entries between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [FIELD_BITS-1:0] WINDOW_LOW_RESET  = 32'h0000_0000;
  localparam logic [FIELD_BITS-1:0] WINDOW_HIGH_RESET = 32'h0001_0000;

  typedef enum logic [0:0] {
    REG_WINDOW_LOW  = 1'b0,
    REG_WINDOW_HIGH = 1'b1
  } reg_index_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ORDER = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_SAT   = 2'd3
  } status_e;

endpackage

// ----- rtl/swa_front.sv -----
// ----------------------------------------------------------------------------
// swa_front: point classifier
// Clips each point's segments against the window and checks key order.
// Emits one queue entry per point: the closing segment of the prior point,
// the forward segment of a last point, an order fault flag and the last flag.
// ----------------------------------------------------------------------------
module swa_front #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  localparam int ENTRY_W   = 2 * KEY_BITS + 2 * VALUE_BITS + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  input  logic [KEY_BITS-1:0]   win_lo_i,
  input  logic [KEY_BITS-1:0]   win_hi_i,
  output logic                  entry_valid_o,
  input  logic                  entry_ready_i,
  output logic [ENTRY_W-1:0]    entry_data_o
);

  localparam int DIFF_W = KEY_BITS + 1;

  logic signed [KEY_BITS-1:0]   prior_key_q, prior_key_d;
  logic signed [VALUE_BITS-1:0] prior_value_q, prior_value_d;
  logic                         seen_q, seen_d;

  logic signed [KEY_BITS-1:0]   key_s, lo_s, hi_s;
  logic signed [KEY_BITS-1:0]   seg_end, start_a, start_b;
  logic        [DIFF_W-1:0]     diff_a, diff_b;
  logic        [KEY_BITS-1:0]   len_a, len_b;
  logic        [VALUE_BITS-1:0] val_a;
  logic                         fault;
  logic                         accept;

  assign key_s = $signed(key_i);
  assign lo_s  = $signed(win_lo_i);
  assign hi_s  = $signed(win_hi_i);

  // Pass the handshake straight to the queue
  assign entry_valid_o = s_valid_i;
  assign s_ready_o     = entry_ready_i;
  assign accept        = s_valid_i && entry_ready_i;

  // Clip the closing segment; the first point extends back to the window start
  always_comb begin
    seg_end = (key_s < hi_s) ? key_s : hi_s;
    if (seen_q) begin
      start_a = (prior_key_q > lo_s) ? prior_key_q : lo_s;
    end else begin
      start_a = lo_s;
    end
    fault  = seen_q && (key_s <= prior_key_q);
    diff_a = DIFF_W'(seg_end) - DIFF_W'(start_a);
    len_a  = (!fault && (seg_end > start_a)) ? diff_a[KEY_BITS-1:0] : '0;
    val_a  = seen_q ? prior_value_q : value_i;
  end

  // Clip the forward segment of a last point up to the window end
  always_comb begin
    start_b = (key_s > lo_s) ? key_s : lo_s;
    diff_b  = DIFF_W'(hi_s) - DIFF_W'(start_b);
    len_b   = (last_i && (hi_s > start_b)) ? diff_b[KEY_BITS-1:0] : '0;
  end

  assign entry_data_o = {last_i, fault, value_i, len_b, val_a, len_a};

  // Track the prior point; a last point ends the series
  always_comb begin
    prior_key_d   = prior_key_q;
    prior_value_d = prior_value_q;
    seen_d        = seen_q;
    if (accept) begin
      if (last_i) begin
        prior_key_d   = '0;
        prior_value_d = '0;
        seen_d        = 1'b0;
      end else begin
        prior_key_d   = key_s;
        prior_value_d = $signed(value_i);
        seen_d        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_key_q   <= '0;
      prior_value_q <= '0;
      seen_q        <= 1'b0;
    end else begin
      prior_key_q   <= prior_key_d;
      prior_value_q <= prior_value_d;
      seen_q        <= seen_d;
    end
  end

endmodule

// ----- rtl/swa_queue.sv -----
// ----------------------------------------------------------------------------
// swa_queue: entry queue between front and back
// Small first-in first-out buffer so that each side stalls on its own.
// ----------------------------------------------------------------------------
module swa_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  import swa_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/swa_back.sv -----
// ----------------------------------------------------------------------------
// swa_back: moment accumulator and divider
// Multiplies each clipped segment by its value into a saturating 64-bit
// moment, then on a last point divides by the window width one quotient bit
// per cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
module swa_back #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  localparam int ENTRY_W   = 2 * KEY_BITS + 2 * VALUE_BITS + 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [KEY_BITS-1:0]              win_lo_i,
  input  logic [KEY_BITS-1:0]              win_hi_i,
  input  logic                             entry_valid_i,
  output logic                             entry_ready_o,
  input  logic [ENTRY_W-1:0]               entry_data_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [swa_pkg::FIELD_BITS-1:0]   res_average_o,
  output swa_pkg::status_e                 res_status_o
);

  import swa_pkg::*;

  localparam int PROD_W = KEY_BITS + VALUE_BITS + 1;
  localparam int EXT_W  = ACC_BITS + 2;
  localparam int REM_W  = KEY_BITS + 1;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0]      V_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0]      V_MIN   = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [ACC_BITS-1:0]        Q_LIMIT =
    {{(ACC_BITS-1){1'b0}}, 1'b1} << (VALUE_BITS - 1);
  localparam logic [CNT_BITS-1:0]        CNT_LAST = CNT_BITS'(ACC_BITS - 1);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_MUL_A = 7'b0000010,
    B_ADD_A = 7'b0000100,
    B_ADD_B = 7'b0001000,
    B_PREP  = 7'b0010000,
    B_DIV   = 7'b0100000,
    B_FIN   = 7'b1000000
  } back_state_e;

  back_state_e state_q, state_d;

  // Latched queue entry
  logic        [KEY_BITS-1:0]   len_a_q, len_a_d, len_b_q, len_b_d;
  logic signed [VALUE_BITS-1:0] val_a_q, val_a_d, val_b_q, val_b_d;
  logic                         ent_fault_q, ent_fault_d, ent_last_q, ent_last_d;

  // Series state
  logic signed [ACC_BITS-1:0]   sum_q, sum_d;
  logic                         fault_q, fault_d, sat_q, sat_d;

  // Multiplier and adder
  logic signed [PROD_W-1:0]     prod_q, prod_d;
  logic        [KEY_BITS-1:0]   mul_len;
  logic signed [VALUE_BITS-1:0] mul_val;
  logic signed [EXT_W-1:0]      total;
  logic                         ovf_hi, ovf_lo;
  logic signed [ACC_BITS-1:0]   sat_sum;

  // Divider
  logic        [KEY_BITS-1:0]   rem_q, rem_d;
  logic        [ACC_BITS-1:0]   dvd_q, dvd_d;
  logic        [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic signed [KEY_BITS-1:0]   lo_s, hi_s;
  logic        [REM_W-1:0]      span, rem_sh, rem_sub;
  logic        [KEY_BITS-1:0]   divisor, rem_next;
  logic                         fits, empty, neg, q_clip;
  logic        [ACC_BITS-1:0]   sum_mag;
  logic        [VALUE_BITS-1:0] q_val;

  // Output register
  logic                         res_valid_q, res_valid_d;
  logic        [FIELD_BITS-1:0] res_avg_q, res_avg_d;
  status_e                      res_status_q, res_status_d;

  assign entry_ready_o = (state_q == B_IDLE);
  assign res_valid_o   = res_valid_q;
  assign res_average_o = res_avg_q;
  assign res_status_o  = res_status_q;

  // Share one multiplier between the two segments
  always_comb begin
    mul_len = (state_q == B_MUL_A) ? len_a_q : len_b_q;
    mul_val = (state_q == B_MUL_A) ? val_a_q : val_b_q;
    prod_d  = $signed({1'b0, mul_len}) * mul_val;
  end

  // Add the registered product with saturation to 64 bits
  always_comb begin
    total  = EXT_W'(sum_q) + EXT_W'(prod_q);
    ovf_hi = !total[EXT_W-1] && (total[EXT_W-2:ACC_BITS-1] != '0);
    ovf_lo = total[EXT_W-1] && (total[EXT_W-2:ACC_BITS-1] != '1);
    if (ovf_hi) begin
      sat_sum = ACC_MAX;
    end else if (ovf_lo) begin
      sat_sum = ACC_MIN;
    end else begin
      sat_sum = total[ACC_BITS-1:0];
    end
  end

  // Window width and one restoring divide step
  always_comb begin
    lo_s     = $signed(win_lo_i);
    hi_s     = $signed(win_hi_i);
    empty    = (hi_s <= lo_s);
    span     = REM_W'(hi_s) - REM_W'(lo_s);
    divisor  = span[KEY_BITS-1:0];
    rem_sh   = {rem_q, dvd_q[ACC_BITS-1]};
    rem_sub  = rem_sh - {1'b0, divisor};
    fits     = (rem_sh >= {1'b0, divisor});
    rem_next = fits ? rem_sub[KEY_BITS-1:0] : rem_sh[KEY_BITS-1:0];
    neg      = sum_q[ACC_BITS-1];
    sum_mag  = neg ? (~sum_q + 1'b1) : sum_q;
  end

  // Sign the quotient and clip it to the value range
  always_comb begin
    q_clip = neg ? (dvd_q > Q_LIMIT) : (dvd_q >= Q_LIMIT);
    if (q_clip) begin
      q_val = neg ? V_MIN : V_MAX;
    end else if (neg) begin
      q_val = ~dvd_q[VALUE_BITS-1:0] + 1'b1;
    end else begin
      q_val = dvd_q[VALUE_BITS-1:0];
    end
  end

  // Sequence accumulate, divide and hand-off
  always_comb begin
    state_d      = state_q;
    len_a_d      = len_a_q;
    len_b_d      = len_b_q;
    val_a_d      = val_a_q;
    val_b_d      = val_b_q;
    ent_fault_d  = ent_fault_q;
    ent_last_d   = ent_last_q;
    sum_d        = sum_q;
    fault_d      = fault_q;
    sat_d        = sat_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    cnt_d        = cnt_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_avg_d    = res_avg_q;
    res_status_d = res_status_q;
    case (state_q)
      B_IDLE: begin
        if (entry_valid_i) begin
          {ent_last_d, ent_fault_d, val_b_d, len_b_d, val_a_d, len_a_d} = entry_data_i;
          state_d = B_MUL_A;
        end
      end
      B_MUL_A: begin
        fault_d = fault_q || ent_fault_q;
        state_d = B_ADD_A;
      end
      B_ADD_A: begin
        sum_d   = sat_sum;
        sat_d   = sat_q || ovf_hi || ovf_lo;
        state_d = B_ADD_B;
      end
      B_ADD_B: begin
        sum_d   = sat_sum;
        sat_d   = sat_q || ovf_hi || ovf_lo;
        state_d = ent_last_q ? B_PREP : B_IDLE;
      end
      B_PREP: begin
        rem_d = '0;
        dvd_d = sum_mag;
        cnt_d = '0;
        state_d = (fault_q || empty) ? B_FIN : B_DIV;
      end
      B_DIV: begin
        rem_d = rem_next;
        dvd_d = {dvd_q[ACC_BITS-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = B_FIN;
        end
      end
      B_FIN: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          if (fault_q) begin
            res_avg_d    = '0;
            res_status_d = STATUS_ORDER;
          end else if (empty) begin
            res_avg_d    = '0;
            res_status_d = STATUS_EMPTY;
          end else begin
            res_avg_d    = FIELD_BITS'($signed(q_val));
            res_status_d = (sat_q || q_clip) ? STATUS_SAT : STATUS_OK;
          end
          sum_d   = '0;
          fault_d = 1'b0;
          sat_d   = 1'b0;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sum_q       <= '0;
      fault_q     <= 1'b0;
      sat_q       <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      fault_q     <= fault_d;
      sat_q       <= sat_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_a_q      <= len_a_d;
    len_b_q      <= len_b_d;
    val_a_q      <= val_a_d;
    val_b_q      <= val_b_d;
    ent_fault_q  <= ent_fault_d;
    ent_last_q   <= ent_last_d;
    prod_q       <= prod_d;
    rem_q        <= rem_d;
    dvd_q        <= dvd_d;
    res_avg_q    <= res_avg_d;
    res_status_q <= res_status_d;
  end

endmodule

// ----- rtl/step_function_window_average.sv -----
// Result path: a last point passes the queue, then the back's multiply-accumulate, setup,
//   divide (skipped on an order fault or an empty window) and finish states.
// Throughput: the back takes no new point until it has finished the one before; a 2-entry
//   queue takes points one per cycle until full.
// Reset: asynchronous, clears series state, queue and output valid; the window
//   registers return to 0 and 1.0.
// ----------------------------------------------------------------------------
// step_function_window_average: time-weighted average of a step function
// Front classifies and clips each point, a queue decouples it from the back,
// which accumulates the moment and divides by the window width.
// ----------------------------------------------------------------------------
module step_function_window_average #(
  parameter int KEY_BITS   = swa_pkg::KEY_BITS_DEFAULT,
  parameter int VALUE_BITS = swa_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  swa_pkg::reg_index_e                 cfg_index_i,
  input  logic [swa_pkg::FIELD_BITS-1:0]      cfg_data_i,
  // Point stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swa_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // point_key, point_value
  input  logic                                s_axis_tlast,  // last_point
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [swa_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata   // window_average,
                                                             // result_status, zero pad
);

  import swa_pkg::*;

  localparam int ENTRY_W = 2 * KEY_BITS + 2 * VALUE_BITS + 2;

  logic [KEY_BITS-1:0]   win_lo_q, win_hi_q;
  logic                  fr_valid, fr_ready, bk_valid, bk_ready;
  logic [ENTRY_W-1:0]    fr_data, bk_data;
  logic [FIELD_BITS-1:0] res_average;
  status_e               res_status;

  // Write the window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= WINDOW_LOW_RESET[KEY_BITS-1:0];
      win_hi_q <= WINDOW_HIGH_RESET[KEY_BITS-1:0];
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_LOW:  win_lo_q <= cfg_data_i[KEY_BITS-1:0];
        REG_WINDOW_HIGH: win_hi_q <= cfg_data_i[KEY_BITS-1:0];
        default:         win_lo_q <= win_lo_q;
      endcase
    end
  end

  swa_front #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .key_i         (s_axis_tdata[KEY_BITS-1:0]),
    .value_i       (s_axis_tdata[FIELD_BITS +: VALUE_BITS]),
    .last_i        (s_axis_tlast),
    .win_lo_i      (win_lo_q),
    .win_hi_i      (win_hi_q),
    .entry_valid_o (fr_valid),
    .entry_ready_i (fr_ready),
    .entry_data_o  (fr_data)
  );

  swa_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_data),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  swa_back #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .win_lo_i      (win_lo_q),
    .win_hi_i      (win_hi_q),
    .entry_valid_i (bk_valid),
    .entry_ready_o (bk_ready),
    .entry_data_i  (bk_data),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_average_o (res_average),
    .res_status_o  (res_status)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = OUT_TDATA_BITS'({res_status, res_average});

endmodule

// ----- rtl/swa_checker.sv -----
// ----------------------------------------------------------------------------
// swa_checker: port-level checks for the step function window average
// Watches the result stream and reset; attached to the top level by bind.
// ----------------------------------------------------------------------------
module swa_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [swa_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

  import swa_pkg::*;

  // Hold a stalled result request
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Drop the result request under reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // Zero the average on an order fault or an empty window
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tdata[33:32] == STATUS_ORDER) ||
                      (m_axis_tdata[33:32] == STATUS_EMPTY))
    |-> (m_axis_tdata[31:0] == '0))
    else $error("nonzero average with fault status");

endmodule

bind step_function_window_average swa_checker u_swa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb_step_function_window_average.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_step_function_window_average: self-checking bench for the window average
// Streams point series through the block under several window settings, with
// random gaps and stalls on both sides, and checks each result against an
// in-bench model of the time-weighted average.
// ----------------------------------------------------------------------------
module tb_step_function_window_average;
  import swa_pkg::*;

  localparam int  STALL_LIMIT  = 3000;  // cycles without progress before giving up
  localparam int  DRAIN_CYCLES = 100;   // covers the divider latency
  localparam int  HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int  PHASE_ITEMS  = 85;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] KEY_MIN   = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX   = 32'h7FFF_FFFF;
  localparam longint      SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint      SUM_MIN   = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
  localparam longint      AVG_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      AVG_MIN   = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic        last;
  } point_t;

  typedef struct packed {
    logic [31:0] average;
    status_e     status;
  } average_t;

  // Block ports
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  reg_index_e                cfg_index_i   = REG_WINDOW_LOW;
  logic [FIELD_BITS-1:0]     cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;  // point_key, point_value
  logic                      s_axis_tlast  = 1'b0;  // last_point
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;         // window_average, result_status, pad

  // Stimulus and expectations
  point_t   pending_points[$];
  average_t pending_averages[$];
  int       mismatches    = 0;
  int       sender_gap_max = 0;
  int       sink_stall_max = 0;
  int       hold_requests  = 0;

  // Window settings as the block should hold them
  logic signed [31:0] window_low_q  = WINDOW_LOW_RESET;
  logic signed [31:0] window_high_q = WINDOW_HIGH_RESET;

  // Open series state
  longint run_prior_key   = 0;
  longint run_prior_value = 0;
  bit     run_seen        = 1'b0;
  longint run_moment      = 0;
  bit     run_order_fault = 1'b0;
  bit     run_saturated   = 1'b0;

  step_function_window_average i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Add one segment moment, clipping at the 64-bit range
  function automatic void add_moment(longint seg_len, longint seg_value);
    longint prod;
    prod = seg_len * seg_value;
    if (prod > 0 && run_moment > SUM_MAX - prod) begin
      run_moment    = SUM_MAX;
      run_saturated = 1'b1;
    end else if (prod < 0 && run_moment < SUM_MIN - prod) begin
      run_moment    = SUM_MIN;
      run_saturated = 1'b1;
    end else begin
      run_moment += prod;
    end
  endfunction

  // Fold one accepted point into the series; a last point yields an average
  task automatic fold_point(logic [31:0] key_bits, logic [31:0] value_bits, logic last);
    longint   lo, hi, k, v, seg_start, seg_end, quot;
    average_t res;
    lo = window_low_q;
    hi = window_high_q;
    k  = $signed(key_bits);
    v  = $signed(value_bits);
    if (!run_seen) begin
      // first value reaches back to the window start
      seg_end = (k < hi) ? k : hi;
      if (seg_end > lo) add_moment(seg_end - lo, v);
    end else if (k <= run_prior_key) begin
      run_order_fault = 1'b1;
    end else begin
      seg_start = (run_prior_key > lo) ? run_prior_key : lo;
      seg_end   = (k < hi) ? k : hi;
      if (seg_end > seg_start) add_moment(seg_end - seg_start, run_prior_value);
    end
    if (last) begin
      // last value reaches forward to the window end
      seg_start = (k > lo) ? k : lo;
      if (hi > seg_start) add_moment(hi - seg_start, v);
    end
    run_prior_key   = k;
    run_prior_value = v;
    run_seen        = 1'b1;
    if (last) begin
      quot       = 0;
      res.status = STATUS_OK;
      if (run_order_fault) begin
        res.status = STATUS_ORDER;
      end else if (hi <= lo) begin
        res.status = STATUS_EMPTY;
      end else begin
        quot = run_moment / (hi - lo);
        if (quot > AVG_MAX) begin
          quot          = AVG_MAX;
          run_saturated = 1'b1;
        end else if (quot < AVG_MIN) begin
          quot          = AVG_MIN;
          run_saturated = 1'b1;
        end
        res.status = run_saturated ? STATUS_SAT : STATUS_OK;
      end
      res.average = quot[31:0];
      pending_averages.push_back(res);
      run_prior_key   = 0;
      run_prior_value = 0;
      run_seen        = 1'b0;
      run_moment      = 0;
      run_order_fault = 1'b0;
      run_saturated   = 1'b0;
    end
  endtask

  // Point driver: hold while stalled, wait the drawn gap, then offer the next
  int     send_gap = 0;
  int     gap_left;
  point_t next_point;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      gap_left = send_gap;
      if (s_axis_tvalid && s_axis_tready) begin
        fold_point(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
        gap_left = $urandom_range(0, sender_gap_max);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_points.size() > 0) begin
        next_point = pending_points.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {next_point.value, next_point.key};
        s_axis_tlast  <= next_point.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      send_gap <= gap_left;
    end
  end

  // Result monitor: check each accepted result, then draw a stall
  int       sink_stall  = 0;
  int       hold_left   = 0;
  int       holds_served = 0;
  int       stall_next, hold_next;
  average_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= 0;
      hold_left     <= 0;
    end else begin
      stall_next = (sink_stall > 0) ? sink_stall - 1 : 0;
      hold_next  = (hold_left > 0) ? hold_left - 1 : 0;
      if (hold_requests != holds_served) begin
        hold_next     = HOLD_CYCLES;
        holds_served <= hold_requests;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_averages.size() == 0) begin
          $error("unexpected result: window_average %h, result_status %0d",
                 m_axis_tdata[31:0], m_axis_tdata[33:32]);
          mismatches++;
        end else begin
          want = pending_averages.pop_front();
          if (m_axis_tdata[31:0] !== want.average) begin
            $error("window_average: expected %h, got %h", want.average, m_axis_tdata[31:0]);
            mismatches++;
          end
          if (m_axis_tdata[33:32] !== want.status) begin
            $error("result_status: expected %0d, got %0d", want.status, m_axis_tdata[33:32]);
            mismatches++;
          end
        end
        stall_next = $urandom_range(0, sink_stall_max);
      end
      m_axis_tready <= (stall_next == 0) && (hold_next == 0);
      sink_stall    <= stall_next;
      hold_left     <= hold_next;
    end
  end

  // Watchdog: count cycles with work outstanding and no request moving
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (pending_points.size() == 0 && !s_axis_tvalid && pending_averages.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(reg_index_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == REG_WINDOW_LOW) window_low_q = data;
    else window_high_q = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_window(logic [31:0] lo, logic [31:0] hi);
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
  endtask

  task automatic push_point(logic [31:0] key, logic [31:0] value, logic last);
    point_t p;
    p.key   = key;
    p.value = value;
    p.last  = last;
    pending_points.push_back(p);
  endtask

  // Wait until every point is taken and every result checked, then settle
  task automatic wait_drained();
    while (pending_points.size() != 0 || s_axis_tvalid || pending_averages.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      2:       return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
      default: return {16'($urandom_range(0, 32'hFFFF) - 32'h8000), 16'h0000};
    endcase
  endfunction

  // Push one series with keys spread around the window; a broken series
  // repeats or lowers one key
  task automatic push_series(int len, bit broken);
    longint key, span, width;
    int     bad_at;
    width  = longint'(window_high_q) - longint'(window_low_q);
    span   = (width > 0) ? width / 2 + 1 : 64'd262144;
    if (span > 64'd1073741824) span = 64'd1073741824;
    bad_at = $urandom_range(1, (len > 1) ? len - 1 : 1);
    key    = longint'(window_low_q) - longint'($urandom_range(0, 32'(span * 2)));
    for (int i = 0; i < len; i++) begin
      if (broken && i == bad_at) key -= longint'($urandom_range(0, 32'(span)));
      else if (i > 0) key += longint'($urandom_range(1, 32'(span)));
      if (key > longint'($signed(KEY_MAX))) key = longint'($signed(KEY_MAX));
      if (key < longint'($signed(KEY_MIN))) key = longint'($signed(KEY_MIN));
      push_point(key[31:0], random_value(), i == len - 1);
    end
  endtask

  // Stimulus sequence
  logic [31:0] rand_lo;
  int          phase_items;
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window [0, 1.0]: one point, window inside steps, all keys below,
    // all keys above, repeated and falling keys
    push_point(32'h0000_0000, Q_ONE, 1'b1);
    push_point(32'hFFFF_0000, 32'h0002_0000, 1'b0);
    push_point(32'h0000_4000, 32'hFFFD_0000, 1'b0);
    push_point(32'h0000_C000, 32'h0005_0000, 1'b1);
    push_point(32'hFFFB_0000, 32'h0007_0000, 1'b0);
    push_point(32'hFFFD_0000, 32'hFFFF_0000, 1'b1);
    push_point(32'h0002_0000, 32'h0004_0000, 1'b0);
    push_point(32'h0003_0000, 32'h0009_0000, 1'b1);
    push_point(32'h0000_8000, Q_ONE, 1'b0);
    push_point(32'h0000_8000, 32'h0002_0000, 1'b1);
    push_point(32'h0000_8000, Q_ONE, 1'b0);
    push_point(32'h0000_4000, 32'h0002_0000, 1'b0);
    push_point(32'h0000_C000, 32'h0003_0000, 1'b1);
    wait_drained();

    // Full key range window with extreme keys and values
    set_window(KEY_MIN, KEY_MAX);
    push_point(KEY_MIN, KEY_MAX, 1'b0);
    push_point(32'h0000_0000, KEY_MIN, 1'b0);
    push_point(KEY_MAX, KEY_MAX, 1'b1);
    push_point(KEY_MAX, KEY_MIN, 1'b1);
    wait_drained();

    // Empty window, then order fault over an empty window
    set_window(32'h0000_0000, 32'h0000_0000);
    push_point(32'h0000_0001, 32'h0000_0005, 1'b0);
    push_point(32'h0000_0002, 32'h0000_0006, 1'b1);
    push_point(32'h0000_0003, 32'h0000_0001, 1'b0);
    push_point(32'h0000_0003, 32'h0000_0002, 1'b1);
    wait_drained();

    // Inverted window
    set_window(KEY_MAX, KEY_MIN);
    push_point(32'h0000_0000, 32'h0000_0001, 1'b1);
    push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // Long receiver hold-off while points keep coming back to back
    set_window(32'hFFFE_0000, 32'h0003_0000);
    sender_gap_max = 0;
    sink_stall_max = 0;
    @(posedge clk_i);
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 10; i++) push_series($urandom_range(1, 3), 1'b0);
    wait_drained();

    // Random phases over a range of window settings
    for (int ph = 0; ph < 8; ph++) begin
      rand_lo = $urandom();
      case (ph)
        0: set_window(WINDOW_LOW_RESET, WINDOW_HIGH_RESET);
        1: set_window(rand_lo >>> 4, (rand_lo >>> 4) + $urandom_range(1, 32'h0010_0000));
        2: set_window(KEY_MIN, KEY_MAX);
        3: set_window(rand_lo, rand_lo);
        4: set_window(rand_lo >>> 2, (rand_lo >>> 2) + 32'd1);
        5: set_window(32'h4000_0000 | rand_lo, rand_lo & 32'h3FFF_FFFF);
        6: set_window($urandom(), $urandom());
        default: set_window(KEY_MIN, KEY_MIN + $urandom_range(1, 32'h0100_0000));
      endcase
      sender_gap_max = (ph % 3 == 0) ? 0 : 16;
      sink_stall_max = (ph % 4 == 1) ? 0 : 16;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          7: push_series($urandom_range(2, 6), 1'b1);
          8, 9: begin
            // noise: arbitrary keys and values, last flag at random
            repeat ($urandom_range(1, 3))
              push_point($urandom(), $urandom(), $urandom_range(0, 3) == 0);
          end
          default: push_series($urandom_range(1, 8), 1'b0);
        endcase
        phase_items = pending_points.size() + phase_items;
        // let the driver take the batch before counting the next one
        while (pending_points.size() > 4) @(posedge clk_i);
        phase_items -= pending_points.size();
      end
      push_series(1, 1'b0);
      wait_drained();
    end

    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
